>>> hdl/fha_pkg.sv
// fha_pkg: shared types and codes for the fit heap allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fha_pkg;

   localparam int PW = 17;   // chain position width
   localparam int HW = 14;   // head word width
   localparam int SW = 13;   // size field width

   localparam logic [1:0] OP_FORMAT = 2'd0;
   localparam logic [1:0] OP_ALLOC  = 2'd1;
   localparam logic [1:0] OP_FREE   = 2'd2;
   localparam logic [1:0] OP_QUERY  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOFMT = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_NOMEM = 2'd3;

   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic [1:0] CSR_HEAP_WORDS = 2'd0;
   localparam logic [1:0] CSR_FIT_MODE   = 2'd1;
   localparam logic [1:0] CSR_ALLOW      = 2'd2;
   localparam logic [1:0] CSR_GUARD      = 2'd3;

   typedef struct packed {
      logic [12:0] heap_words;
      logic [1:0]  fit_mode;
      logic        allow_empty;
      logic [7:0]  guard;
   } cfg_type;

   typedef struct packed {
      logic          we;
      logic [PW-1:0] addr;
      logic [HW-1:0] wdata;
   } mem_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] address;
      logic        used;
      logic [14:0] bytes;
   } rsp_type;

endpackage

>>> hdl/fit_heap_allocator.sv
// Word heap allocator with first, best and worst fit over a chain of head words.
// Request channel (req_*): operation, request_bytes, client_address; a transaction
// is taken when req_valid is high and req_stall is low. One transaction is in
// work at a time; req_stall stays high until its response is registered.
// Response channel (rsp_*): status, result_address, block_used, usable_bytes,
// one response per request, held in an output register while rsp_stall is high.
// Allocate and free walk the chain one block at a time, with one head store read
// and one compare per block.
// The head store has a single port with registered read data.
// Configuration (csr_*): write csr_wdata to register csr_index while idle.
// Reset: synchronous; afterwards the head store is cleared one word per cycle,
// all HEAP_WORDS words, with req_stall high. The heap starts unformatted.
// Depends on fha_pkg, fha_seq and fha_mem.
`timescale 1ns / 1ps

module fit_heap_allocator import fha_pkg::*; #(
   parameter int HEAP_WORDS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_request_bytes,
   input  logic [11:0] req_client_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_result_address,
   output logic        rsp_block_used,
   output logic [14:0] rsp_usable_bytes,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   mem_req_type   mreq;
   logic [HW-1:0] rdata;
   logic          idle;
   logic          load;
   logic          rsp_free;
   rsp_type       result;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !idle;

   fha_seq #(.HEAP_WORDS(HEAP_WORDS)) u_seq (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .start          (req_valid),
      .operation      (req_operation),
      .request_bytes  (req_request_bytes),
      .client_address (req_client_address),
      .rsp_free       (rsp_free),
      .rdata          (rdata),
      .mreq           (mreq),
      .idle           (idle),
      .load           (load),
      .result         (result)
   );

   fha_mem #(.HEAP_WORDS(HEAP_WORDS)) u_mem (
      .clock (clock),
      .req   (mreq),
      .rdata (rdata)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_HEAP_WORDS: cfg_in.heap_words  = csr_wdata;
            CSR_FIT_MODE:   cfg_in.fit_mode    = csr_wdata[1:0];
            CSR_ALLOW:      cfg_in.allow_empty = csr_wdata[0];
            CSR_GUARD:      cfg_in.guard       = csr_wdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{heap_words: 13'd4096, fit_mode: 2'd0,
                           allow_empty: 1'b0, guard: 8'd0};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_result_address = rsp_ff.address;
   assign rsp_block_used     = rsp_ff.used;
   assign rsp_usable_bytes   = rsp_ff.bytes;

endmodule

>>> hdl/fha_mem.sv
// fha_mem: head word store, one port, registered read data.
// Depends on fha_pkg.
`timescale 1ns / 1ps

module fha_mem import fha_pkg::*; #(
   parameter int HEAP_WORDS = 4096
) (
   input  logic          clock,
   input  mem_req_type   req,
   output logic [HW-1:0] rdata
);

   localparam int AW = $clog2(HEAP_WORDS);

   logic [HW-1:0] mem [HEAP_WORDS];
   logic [HW-1:0] rdata_ff;
   logic [AW-1:0] idx;

   assign idx   = req.addr[AW-1:0];
   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[idx] <= req.wdata;
      end
      rdata_ff <= mem[idx];
   end

endmodule

>>> hdl/fha_seq.sv
// fha_seq: sequencer that walks the block chain through the head store.
// Depends on fha_pkg; drives fha_mem through a request struct.
`timescale 1ns / 1ps

module fha_seq import fha_pkg::*; #(
   parameter int HEAP_WORDS = 4096
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          start,
   input  logic [1:0]    operation,
   input  logic [15:0]   request_bytes,
   input  logic [11:0]   client_address,
   input  logic          rsp_free,
   input  logic [HW-1:0] rdata,
   output mem_req_type   mreq,
   output logic          idle,
   output logic          load,
   output rsp_type       result
);

   localparam int AW = $clog2(HEAP_WORDS);

   typedef enum logic [17:0] {
      S_CLEAR = 18'h00001, S_IDLE  = 18'h00002, S_START = 18'h00004,
      S_AWALK = 18'h00008, S_ACHK  = 18'h00010, S_AW1   = 18'h00020,
      S_AW2   = 18'h00040, S_FCHK0 = 18'h00080, S_FWALK = 18'h00100,
      S_FCHK  = 18'h00200, S_FNRD  = 18'h00400, S_FNCHK = 18'h00800,
      S_FWT   = 18'h01000, S_FWN   = 18'h02000, S_FWP   = 18'h04000,
      S_QCHK  = 18'h08000, S_RESP  = 18'h10000, S_SPARE = 18'h20000
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [1:0]    op_ff, op_in;
   logic [15:0]   bytes_ff, bytes_in;
   logic [11:0]   client_ff, client_in;
   logic          fmt_ff, fmt_in;
   logic [SW-1:0] hsize_ff, hsize_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [14:0]   unum_ff, unum_in;
   logic          have_ff, have_in;
   logic [PW-1:0] found_ff, found_in;
   logic [SW-1:0] fsize_ff, fsize_in;
   logic [PW-1:0] target_ff, target_in;
   logic [SW-1:0] tsize_ff, tsize_in;
   logic [PW-1:0] prev_ff, prev_in;
   logic [SW-1:0] psize_ff, psize_in;
   logic          hprev_ff, hprev_in;
   logic [14:0]   size_ff, size_in;
   logic [PW-1:0] nxt_ff, nxt_in;
   logic          nmerge_ff, nmerge_in;
   rsp_type       res_ff, res_in;

   logic [16:0]   unum_sum;
   logic [14:0]   unum_c;
   logic [8:0]    off;
   logic [PW-1:0] heap_end;
   logic [PW-1:0] next_pos;
   logic [SW-1:0] hsz;
   logic          pmerge;
   logic [15:0]   usable4;
   logic [15:0]   g8;

   assign unum_sum = 17'(bytes_ff) + {6'd0, cfg.guard, 3'd0} + 17'd3;
   assign unum_c   = unum_sum[16:2];
   assign off      = {1'b0, cfg.guard} + 9'd1;
   assign heap_end = PW'(hsize_ff);
   assign hsz      = rdata[SW-1:0];
   assign next_pos = pos_ff + PW'(hsz) + PW'(1);
   assign pmerge   = hprev_ff && ((prev_ff + PW'(psize_ff) + PW'(1)) == target_ff);
   assign usable4  = {1'b0, hsz, 2'b00};
   assign g8       = {5'd0, cfg.guard, 3'd0};

   assign idle   = (state_ff == S_IDLE);
   assign load   = (state_ff == S_RESP) && rsp_free;
   assign result = res_ff;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      op_in     = op_ff;
      bytes_in  = bytes_ff;
      client_in = client_ff;
      fmt_in    = fmt_ff;
      hsize_in  = hsize_ff;
      pos_in    = pos_ff;
      unum_in   = unum_ff;
      have_in   = have_ff;
      found_in  = found_ff;
      fsize_in  = fsize_ff;
      target_in = target_ff;
      tsize_in  = tsize_ff;
      prev_in   = prev_ff;
      psize_in  = psize_ff;
      hprev_in  = hprev_ff;
      size_in   = size_ff;
      nxt_in    = nxt_ff;
      nmerge_in = nmerge_ff;
      res_in    = res_ff;
      mreq      = '{we: 1'b0, addr: pos_ff, wdata: '0};

      unique case (state_ff)
         S_CLEAR: begin
            mreq = '{we: 1'b1, addr: PW'(clr_ff), wdata: '0};
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(HEAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in     = operation;
               bytes_in  = request_bytes;
               client_in = client_address;
               state_in  = S_START;
            end
         end
         S_START: begin
            res_in   = '{status: ST_OK, address: '0, used: 1'b0, bytes: '0};
            state_in = S_RESP;
            if (op_ff == OP_FORMAT) begin
               if ((32'(cfg.heap_words) > HEAP_WORDS) ||
                   ({3'd0, cfg.heap_words} <= {7'd0, cfg.guard, 1'b0}) ||
                   (({3'd0, cfg.heap_words} == {7'd0, cfg.guard, 1'b0} + 16'd1)
                    && !cfg.allow_empty)) begin
                  res_in.status = ST_NOFMT;
               end else begin
                  fmt_in   = 1'b1;
                  hsize_in = cfg.heap_words;
                  mreq = '{we: 1'b1, addr: '0, wdata: HW'(cfg.heap_words - 13'd1)};
               end
            end else if (!fmt_ff) begin
               res_in.status = ST_NOFMT;
            end else if (op_ff == OP_ALLOC) begin
               unum_in = unum_c;
               pos_in  = '0;
               have_in = 1'b0;
               if (unum_c > 15'(hsize_ff)) begin
                  res_in.status = ST_NOMEM;
               end else if ((unum_c == 15'd0) && !cfg.allow_empty) begin
                  res_in.status = ST_RANGE;
               end else begin
                  state_in = S_AWALK;
               end
            end else begin
               target_in = PW'(client_ff) - PW'(off);
               if ((12'(off) > client_ff) ||
                   ((PW'(client_ff) - PW'(off)) >= heap_end)) begin
                  res_in.status = ST_RANGE;
               end else begin
                  mreq.addr = PW'(client_ff) - PW'(off);
                  state_in  = (op_ff == OP_FREE) ? S_FCHK0 : S_QCHK;
               end
            end
         end
         S_AWALK: begin
            if (pos_ff >= heap_end) begin
               if (!have_ff) begin
                  res_in.status = ST_NOMEM;
                  state_in = S_RESP;
               end else begin
                  state_in = S_AW1;
               end
            end else begin
               state_in = S_ACHK;
            end
         end
         S_ACHK: begin
            pos_in   = next_pos;
            state_in = S_AWALK;
            if (!rdata[SW] && (15'(hsz) >= unum_ff)) begin
               if (!have_ff) begin
                  have_in  = 1'b1;
                  found_in = pos_ff;
                  fsize_in = hsz;
                  if ((cfg.fit_mode != FIT_BEST) && (cfg.fit_mode != FIT_WORST)) begin
                     state_in = S_AW1;
                  end
               end else if (((cfg.fit_mode == FIT_BEST) && (hsz < fsize_ff)) ||
                            ((cfg.fit_mode == FIT_WORST) && (hsz > fsize_ff))) begin
                  found_in = pos_ff;
                  fsize_in = hsz;
               end
            end
         end
         S_AW1: begin
            res_in.address = 12'(found_ff + PW'(1) + PW'(cfg.guard));
            if (16'(fsize_ff) <= 16'(unum_ff) + (cfg.allow_empty ? 16'd0 : 16'd1)) begin
               mreq = '{we: 1'b1, addr: found_ff, wdata: {1'b1, fsize_ff}};
               state_in = S_RESP;
            end else begin
               mreq = '{we: 1'b1, addr: found_ff + PW'(unum_ff) + PW'(1),
                        wdata: HW'(fsize_ff - unum_ff[SW-1:0] - 13'd1)};
               state_in = S_AW2;
            end
         end
         S_AW2: begin
            mreq = '{we: 1'b1, addr: found_ff, wdata: {1'b1, unum_ff[SW-1:0]}};
            state_in = S_RESP;
         end
         S_FCHK0: begin
            tsize_in = hsz;
            pos_in   = '0;
            hprev_in = 1'b0;
            state_in = rdata[SW] ? S_FWALK : S_RESP;
         end
         S_FWALK: begin
            if (pos_ff >= heap_end) begin
               res_in.status = ST_RANGE;
               state_in = S_RESP;
            end else if (pos_ff == target_ff) begin
               state_in = S_FNRD;
            end else begin
               state_in = S_FCHK;
            end
         end
         S_FCHK: begin
            if (!rdata[SW]) begin
               prev_in  = pos_ff;
               psize_in = hsz;
               hprev_in = 1'b1;
            end
            pos_in   = next_pos;
            state_in = S_FWALK;
         end
         S_FNRD: begin
            size_in   = 15'(tsize_ff);
            nxt_in    = target_ff + PW'(tsize_ff) + PW'(1);
            nmerge_in = 1'b0;
            mreq.addr = target_ff + PW'(tsize_ff) + PW'(1);
            state_in  = ((target_ff + PW'(tsize_ff) + PW'(1)) < heap_end) ? S_FNCHK : S_FWT;
         end
         S_FNCHK: begin
            if (!rdata[SW]) begin
               size_in   = size_ff + 15'(hsz) + 15'd1;
               nmerge_in = 1'b1;
            end
            state_in = S_FWT;
         end
         S_FWT: begin
            mreq = '{we: 1'b1, addr: target_ff, wdata: pmerge ? '0 : size_ff[HW-1:0]};
            state_in = S_FWN;
         end
         S_FWN: begin
            mreq = '{we: nmerge_ff, addr: nxt_ff, wdata: '0};
            state_in = S_FWP;
         end
         S_FWP: begin
            mreq = '{we: pmerge, addr: prev_ff,
                     wdata: HW'(15'(psize_ff) + size_ff + 15'd1)};
            state_in = S_RESP;
         end
         S_QCHK: begin
            res_in.used  = rdata[SW];
            res_in.bytes = (usable4 > g8) ? 15'(usable4 - g8) : 15'd0;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         fmt_ff   <= 1'b0;
         hsize_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         fmt_ff   <= fmt_in;
         hsize_ff <= hsize_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      bytes_ff  <= bytes_in;
      client_ff <= client_in;
      pos_ff    <= pos_in;
      unum_ff   <= unum_in;
      have_ff   <= have_in;
      found_ff  <= found_in;
      fsize_ff  <= fsize_in;
      target_ff <= target_in;
      tsize_ff  <= tsize_in;
      prev_ff   <= prev_in;
      psize_ff  <= psize_in;
      hprev_ff  <= hprev_in;
      size_ff   <= size_in;
      nxt_ff    <= nxt_in;
      nmerge_ff <= nmerge_in;
      res_ff    <= res_in;
   end

endmodule
